[src/evis_pkg.sv]
// Package for the environment string injection screen.
// Holds word types, widths, verdict codes and scan phases.
// No dependencies.
package evis_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DEPTH_WIDTH = 16;
  localparam int MAX_VARS_WIDTH = 16;
  localparam int INDEX_WIDTH = 16;

  localparam logic [MAX_VARS_WIDTH-1:0] MAX_VARS_RESET = 16'd200;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_TOO_MANY  = 3'd1,
    VERDICT_BAD_NAME  = 3'd2,
    VERDICT_EMPTY_PAR = 3'd3,
    VERDICT_UNMATCHED = 3'd4,
    VERDICT_UNCLOSED  = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       list_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]             verdict;
    logic [INDEX_WIDTH-1:0] var_index;
  } out_word_t;

endpackage

[src/evis_scan.sv]
// Scan state and per-byte update of the injection screen.
// Depends on evis_pkg; one word processed per step.
module evis_scan import evis_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  in_word_t                  word,
  input  logic [MAX_VARS_WIDTH-1:0] max_vars,
  output out_word_t                 result
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [DEPTH_WIDTH-1:0] depth_r, depth_nxt;
  logic                   neg_r, neg_nxt;
  logic                   open_r, open_nxt;
  logic                   empty_r, empty_nxt;
  verdict_t               held_r, held_nxt;
  logic [COUNT_WIDTH-1:0] held_idx_r, held_idx_nxt;

  always_comb begin
    logic [7:0] b;
    verdict_t   fin;
    b            = word.data_byte;
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    depth_nxt    = depth_r;
    neg_nxt      = neg_r;
    open_nxt     = open_r;
    empty_nxt    = empty_r;
    held_nxt     = held_r;
    held_idx_nxt = held_idx_r;
    fin          = VERDICT_ACCEPT;
    result       = '0;

    // value-end judgment on current flags
    if (empty_r) begin
      fin = VERDICT_EMPTY_PAR;
    end else if (neg_r) begin
      fin = VERDICT_UNMATCHED;
    end else if (depth_r != '0) begin
      fin = VERDICT_UNCLOSED;
    end

    if (word.list_end) begin
      if (held_r != VERDICT_ACCEPT) begin
        result.verdict   = held_r;
        result.var_index = INDEX_WIDTH'(held_idx_r);
      end else if (phase_r == PH_VALUE && fin != VERDICT_ACCEPT) begin
        result.verdict   = fin;
        result.var_index = INDEX_WIDTH'(count_r);
      end else begin
        result.verdict   = VERDICT_ACCEPT;
        result.var_index = INDEX_WIDTH'(count_r);
      end
      phase_nxt    = PH_START;
      count_nxt    = '0;
      depth_nxt    = '0;
      neg_nxt      = 1'b0;
      open_nxt     = 1'b0;
      empty_nxt    = 1'b0;
      held_nxt     = VERDICT_ACCEPT;
      held_idx_nxt = '0;
    end else if (held_r == VERDICT_ACCEPT) begin
      if (phase_r == PH_START) begin
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
        if (count_nxt > COUNT_WIDTH'(max_vars)) begin
          held_nxt     = VERDICT_TOO_MANY;
          held_idx_nxt = count_nxt;
        end else begin
          depth_nxt = '0;
          neg_nxt   = 1'b0;
          open_nxt  = 1'b0;
          empty_nxt = 1'b0;
          phase_nxt = PH_NAME;
        end
      end
      case (phase_r)
        PH_START, PH_NAME: begin
          if (held_nxt == VERDICT_ACCEPT) begin
            if (b == CH_NUL) begin
              phase_nxt = PH_START;
            end else if (b <= CH_SPACE || b >= CH_HIGH) begin
              phase_nxt = PH_SKIP;
            end else if (b == CH_EQ) begin
              phase_nxt = PH_VALUE;
            end else if (b < CH_PLUS || b > CH_Z) begin
              held_nxt     = VERDICT_BAD_NAME;
              held_idx_nxt = count_nxt;
            end
          end
        end
        PH_VALUE: begin
          if (b == CH_NUL) begin
            if (fin != VERDICT_ACCEPT) begin
              held_nxt     = fin;
              held_idx_nxt = count_r;
            end
            phase_nxt = PH_START;
          end else begin
            if (b == CH_CLOSE && open_r) begin
              empty_nxt = 1'b1;
            end
            if (!neg_r) begin
              if (b == CH_OPEN) begin
                if (depth_r != DEPTH_MAX) begin
                  depth_nxt = depth_r + 1'b1;
                end
              end else if (b == CH_CLOSE) begin
                if (depth_r == '0) begin
                  neg_nxt = 1'b1;
                end else begin
                  depth_nxt = depth_r - 1'b1;
                end
              end
            end
            open_nxt = (b == CH_OPEN);
          end
        end
        default: begin
          if (b == CH_NUL) begin
            phase_nxt = PH_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      count_r    <= '0;
      depth_r    <= '0;
      neg_r      <= 1'b0;
      open_r     <= 1'b0;
      empty_r    <= 1'b0;
      held_r     <= VERDICT_ACCEPT;
      held_idx_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      depth_r    <= depth_nxt;
      neg_r      <= neg_nxt;
      open_r     <= open_nxt;
      empty_r    <= empty_nxt;
      held_r     <= held_nxt;
      held_idx_r <= held_idx_nxt;
    end
  end

endmodule

[src/env_var_injection_screen.sv]
// Top level of the environment string injection screen.
// Depends on evis_pkg and evis_scan.
//
//   channel  direction  word        handshake
//   in_      input      in_word_t   in_valid / in_stall
//   out_     output     out_word_t  out_valid / out_stall
//   cfg_     input      max_vars    cfg_wr_en / cfg_wr_data
//
// One word per cycle while in_stall is low. A byte is registered, then scanned
// from that register; a list-end word then has its verdict written into the result
// register. in_stall rises only when a list-end word waits on a full, stalled
// result register. Reset is synchronous; max_vars returns to 200.
module env_var_injection_screen import evis_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_word_t                  in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_word_t                 out_word,
  input  logic                      cfg_wr_en,
  input  logic [MAX_VARS_WIDTH-1:0] cfg_wr_data
);

  in_word_t                  inq_r;
  logic                      inq_v_r;
  out_word_t                 out_r;
  logic                      out_v_r;
  logic [MAX_VARS_WIDTH-1:0] max_vars_r;
  logic                      advance;
  logic                      take;
  out_word_t                 result;

  assign advance  = inq_v_r && (!inq_r.list_end || !out_v_r || !out_stall);
  assign in_stall = inq_v_r && !advance;
  assign take     = in_valid && !in_stall;

  evis_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .word     (inq_r),
    .max_vars (max_vars_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vars_r <= MAX_VARS_RESET;
    end else if (cfg_wr_en) begin
      max_vars_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r <= 1'b0;
    end else if (take) begin
      inq_v_r <= 1'b1;
    end else if (advance) begin
      inq_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      inq_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && inq_r.list_end) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && inq_r.list_end) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule
